@@ rtl/sbsm_pkg.sv @@
package sbsm_pkg;

   localparam int PRG_RAM_BYTES_DEF = 8192;

   localparam int OP_W      = 2;
   localparam int ADDR_W    = 16;
   localparam int DATA_W    = 8;
   localparam int TARGET_W  = 2;
   localparam int MAP_W     = 18;
   localparam int MIRROR_W  = 2;
   localparam int CFG_W     = 5;
   localparam int CFG_IDX_W = 1;
   localparam int SHIFT_W   = 8;
   localparam int BANK_W    = 5;
   localparam int PRG_SEL_W = 4;
   localparam int RAM_OFF_W = 13;

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 32;

   localparam logic [OP_W-1:0] OP_CPU_READ  = 2'd0;
   localparam logic [OP_W-1:0] OP_CPU_WRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_PPU       = 2'd2;

   localparam logic [TARGET_W-1:0] TARGET_PRG_RAM = 2'd0;
   localparam logic [TARGET_W-1:0] TARGET_PRG_ROM = 2'd1;
   localparam logic [TARGET_W-1:0] TARGET_CHR    = 2'd2;
   localparam logic [TARGET_W-1:0] TARGET_NONE   = 2'd3;

   localparam logic [1:0] SEL_CONTROL = 2'd0;
   localparam logic [1:0] SEL_CHR0    = 2'd1;
   localparam logic [1:0] SEL_CHR1    = 2'd2;
   localparam logic [1:0] SEL_PRG     = 2'd3;

   localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
   localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

   localparam logic [CFG_IDX_W-1:0] CFG_PRG_ROM_BANKS = 1'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_CHR_ROM_UNITS = 1'd1;

   localparam logic [SHIFT_W-1:0] SHIFT_MARK = 8'h80;

endpackage

@@ rtl/sbsm_ram.sv @@
module sbsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/serial_bank_switch_mapper.sv @@
// cartridge bank mapper with a five-bit serial register interface
// req channel: one bus access per word (op, address, write_data); cpu reads
// at 0x6000..0xffff, writes at 0x6000..0x7fff and ppu below 0x2000 are mapped
// rsp channel: exactly one word per request, in order, with target, mapped
// address, prg ram read data, mirroring and the stored ram enable bit
// csr port: csr_we with csr_index 0 (prg rom banks) or 1 (chr rom units)
// pipeline: an accepted request passes the stage for the synchronous prg ram
// read and then the output register, which presents its response
// throughput: one request per cycle while req_tready is high; register state
// updates at acceptance so back to back serial register writes need no bubble
// reset: the serial register returns to its marker, control registers take
// their defaults, and the prg ram is swept to zero one byte per cycle over
// all PRG_RAM_BYTES bytes (8192 by default) with req_tready held low;
// csr writes are taken during the sweep
// stall: with rsp_tready low the output register and one staged request hold,
// so one more request is taken before req_tready drops
module serial_bank_switch_mapper #(
   parameter int PRG_RAM_BYTES = sbsm_pkg::PRG_RAM_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // op[1:0], address[17:2], write_data[25:18], zero[31:26]
   input  logic [sbsm_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // target[1:0], mapped_address[19:2], read_data[27:20], mirroring[29:28],
   // ram_enable_bit[30], zero[31]
   output logic [sbsm_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_we,
   input  logic [sbsm_pkg::CFG_IDX_W-1:0]      csr_index,
   input  logic [sbsm_pkg::CFG_W-1:0]          csr_wdata
);

   localparam int RAM_AW = $clog2(PRG_RAM_BYTES);

   // request fields
   logic [sbsm_pkg::OP_W-1:0]   req_op;
   logic [sbsm_pkg::ADDR_W-1:0] req_addr;
   logic [sbsm_pkg::DATA_W-1:0] req_data;

   assign req_op   = req_tdata[1:0];
   assign req_addr = req_tdata[17:2];
   assign req_data = req_tdata[25:18];

   // configuration
   logic [sbsm_pkg::CFG_W-1:0] prg_rom_banks_ff, prg_rom_banks_in;
   logic [sbsm_pkg::CFG_W-1:0] chr_rom_units_ff, chr_rom_units_in;

   // mapper state
   logic [sbsm_pkg::SHIFT_W-1:0]   shift_ff, shift_in;
   logic                           chr_split_ff, chr_split_in;
   logic [1:0]                     prg_mode_ff, prg_mode_in;
   logic [sbsm_pkg::MIRROR_W-1:0]  mirror_ff, mirror_in;
   logic [sbsm_pkg::BANK_W-1:0]    chr_low_ff, chr_low_in;
   logic [sbsm_pkg::BANK_W-1:0]    chr_high_ff, chr_high_in;
   logic [sbsm_pkg::PRG_SEL_W-1:0] prg_sel_ff, prg_sel_in;
   logic                           ram_en_ff, ram_en_in;

   // clearing sweep
   logic              clr_active_ff, clr_active_in;
   logic [RAM_AW-1:0] clr_addr_ff, clr_addr_in;

   // stage 1: ram read in flight
   logic                            s1_valid_ff, s1_valid_in;
   logic [sbsm_pkg::TARGET_W-1:0]   s1_target_ff;
   logic [sbsm_pkg::MAP_W-1:0]      s1_map_ff;
   logic                            s1_read_ff;
   logic [sbsm_pkg::MIRROR_W-1:0]   s1_mirror_ff;
   logic                            s1_ram_en_ff;

   // stage 2: output register
   logic                            s2_valid_ff, s2_valid_in;
   logic [sbsm_pkg::TARGET_W-1:0]   s2_target_ff;
   logic [sbsm_pkg::MAP_W-1:0]      s2_map_ff;
   logic [sbsm_pkg::DATA_W-1:0]     s2_rdata_ff;
   logic [sbsm_pkg::MIRROR_W-1:0]   s2_mirror_ff;
   logic                            s2_ram_en_ff;

   logic s2_load;
   logic s1_move;
   logic acc;

   // decode of the accepted word
   logic                          is_cpu;
   logic                          cpu_rom;
   logic                          cpu_ram;
   logic                          ppu_chr;
   logic [sbsm_pkg::TARGET_W-1:0] tgt;
   logic [sbsm_pkg::MAP_W-1:0]    map_addr;
   logic [sbsm_pkg::MAP_W-1:0]    prg_addr;
   logic [sbsm_pkg::MAP_W-1:0]    chr_addr;
   logic [sbsm_pkg::CFG_W-1:0]    last_bank;
   logic [sbsm_pkg::SHIFT_W-1:0]  shifted;
   logic [4:0]                    commit_val;

   // ram port
   logic                       ram_en;
   logic                       ram_we;
   logic [RAM_AW-1:0]          ram_addr;
   logic [sbsm_pkg::DATA_W-1:0] ram_wdata;
   logic [sbsm_pkg::DATA_W-1:0] ram_rdata;

   assign s2_load    = !s2_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && s2_load;
   assign req_tready = !clr_active_ff && (!s1_valid_ff || s2_load);
   assign acc        = req_tvalid && req_tready;

   assign is_cpu  = (req_op == sbsm_pkg::OP_CPU_READ) || (req_op == sbsm_pkg::OP_CPU_WRITE);
   assign cpu_rom = is_cpu && req_addr[15];
   assign cpu_ram = is_cpu && !req_addr[15] && (req_addr[14:13] == 2'b11);
   assign ppu_chr = (req_op == sbsm_pkg::OP_PPU) && (req_addr[15:13] == 3'b000);

   assign last_bank = (prg_rom_banks_ff == '0) ? '0 : prg_rom_banks_ff - 5'd1;

   always_comb begin
      case (prg_mode_ff)
         sbsm_pkg::PRG_MODE_FIX_FIRST: begin
            if (!req_addr[14]) begin
               prg_addr = {4'd0, req_addr[13:0]};
            end else begin
               prg_addr = {prg_sel_ff, req_addr[13:0]};
            end
         end
         sbsm_pkg::PRG_MODE_FIX_LAST: begin
            if (!req_addr[14]) begin
               prg_addr = {prg_sel_ff, req_addr[13:0]};
            end else begin
               prg_addr = {last_bank[3:0], req_addr[13:0]};
            end
         end
         default: begin
            prg_addr = {prg_sel_ff[3:1], req_addr[14:0]};
         end
      endcase
   end

   always_comb begin
      if (chr_split_ff) begin
         if (!req_addr[12]) begin
            chr_addr = {1'b0, chr_low_ff, req_addr[11:0]};
         end else begin
            chr_addr = {1'b0, chr_high_ff, req_addr[11:0]};
         end
      end else begin
         chr_addr = {1'b0, chr_low_ff[4:1], req_addr[12:0]};
      end
   end

   always_comb begin
      tgt      = sbsm_pkg::TARGET_NONE;
      map_addr = '0;
      if (cpu_ram) begin
         tgt      = sbsm_pkg::TARGET_PRG_RAM;
         map_addr = {5'd0, req_addr[12:0]};
      end else if (cpu_rom && (req_op == sbsm_pkg::OP_CPU_READ)) begin
         tgt      = sbsm_pkg::TARGET_PRG_ROM;
         map_addr = prg_addr;
      end else if (ppu_chr) begin
         tgt      = sbsm_pkg::TARGET_CHR;
         map_addr = chr_addr;
      end
   end

   // serial register and commit
   assign shifted    = {req_data[0], shift_ff[7:1]};
   assign commit_val = shifted[7:3];

   always_comb begin
      shift_in     = shift_ff;
      chr_split_in = chr_split_ff;
      prg_mode_in  = prg_mode_ff;
      mirror_in    = mirror_ff;
      chr_low_in   = chr_low_ff;
      chr_high_in  = chr_high_ff;
      prg_sel_in   = prg_sel_ff;
      ram_en_in    = ram_en_ff;
      if (acc && cpu_rom && (req_op == sbsm_pkg::OP_CPU_WRITE)) begin
         if (req_data[7]) begin
            shift_in    = sbsm_pkg::SHIFT_MARK;
            prg_mode_in = sbsm_pkg::PRG_MODE_FIX_LAST;
         end else if (!shift_ff[3]) begin
            shift_in = shifted;
         end else begin
            shift_in = sbsm_pkg::SHIFT_MARK;
            case (req_addr[14:13])
               sbsm_pkg::SEL_CONTROL: begin
                  chr_split_in = commit_val[4];
                  prg_mode_in  = commit_val[3:2];
                  mirror_in    = commit_val[1:0];
               end
               sbsm_pkg::SEL_CHR0: begin
                  chr_low_in = (chr_rom_units_ff == '0) ? {4'd0, commit_val[0]} : commit_val;
               end
               sbsm_pkg::SEL_CHR1: begin
                  chr_high_in = commit_val;
               end
               sbsm_pkg::SEL_PRG: begin
                  ram_en_in  = commit_val[4];
                  prg_sel_in = commit_val[3:0];
               end
               default: begin
                  chr_high_in = chr_high_ff;
               end
            endcase
         end
      end
   end

   always_comb begin
      prg_rom_banks_in = prg_rom_banks_ff;
      chr_rom_units_in = chr_rom_units_ff;
      if (csr_we) begin
         case (csr_index)
            sbsm_pkg::CFG_PRG_ROM_BANKS: prg_rom_banks_in = csr_wdata;
            sbsm_pkg::CFG_CHR_ROM_UNITS: chr_rom_units_in = csr_wdata;
            default: prg_rom_banks_in = prg_rom_banks_ff;
         endcase
      end
   end

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == RAM_AW'(PRG_RAM_BYTES - 1)) begin
            clr_active_in = 1'b0;
         end
      end
   end

   // ram access
   assign ram_en    = clr_active_ff || (acc && cpu_ram);
   assign ram_we    = clr_active_ff || (req_op == sbsm_pkg::OP_CPU_WRITE);
   assign ram_addr  = clr_active_ff ? clr_addr_ff : RAM_AW'(req_addr[12:0]);
   assign ram_wdata = clr_active_ff ? '0 : req_data;

   sbsm_ram #(
      .WIDTH(sbsm_pkg::DATA_W),
      .DEPTH(PRG_RAM_BYTES)
   ) u_prg_ram (
      .clock(clock),
      .en   (ram_en),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      s2_valid_in = s2_valid_ff;
      if (s2_load) begin
         s2_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_rom_banks_ff <= 5'd16;
         chr_rom_units_ff <= '0;
         shift_ff         <= sbsm_pkg::SHIFT_MARK;
         chr_split_ff     <= 1'b0;
         prg_mode_ff      <= sbsm_pkg::PRG_MODE_FIX_LAST;
         mirror_ff        <= '0;
         chr_low_ff       <= '0;
         chr_high_ff      <= 5'd1;
         prg_sel_ff       <= '0;
         ram_en_ff        <= 1'b0;
         clr_active_ff    <= 1'b1;
         clr_addr_ff      <= '0;
         s1_valid_ff      <= 1'b0;
         s2_valid_ff      <= 1'b0;
      end else begin
         prg_rom_banks_ff <= prg_rom_banks_in;
         chr_rom_units_ff <= chr_rom_units_in;
         shift_ff         <= shift_in;
         chr_split_ff     <= chr_split_in;
         prg_mode_ff      <= prg_mode_in;
         mirror_ff        <= mirror_in;
         chr_low_ff       <= chr_low_in;
         chr_high_ff      <= chr_high_in;
         prg_sel_ff       <= prg_sel_in;
         ram_en_ff        <= ram_en_in;
         clr_active_ff    <= clr_active_in;
         clr_addr_ff      <= clr_addr_in;
         s1_valid_ff      <= s1_valid_in;
         s2_valid_ff      <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_target_ff <= tgt;
         s1_map_ff    <= map_addr;
         s1_read_ff   <= cpu_ram && (req_op == sbsm_pkg::OP_CPU_READ);
         s1_mirror_ff <= mirror_in;
         s1_ram_en_ff <= ram_en_in;
      end
      if (s2_load && s1_valid_ff) begin
         s2_target_ff <= s1_target_ff;
         s2_map_ff    <= s1_map_ff;
         s2_rdata_ff  <= s1_read_ff ? ram_rdata : '0;
         s2_mirror_ff <= s1_mirror_ff;
         s2_ram_en_ff <= s1_ram_en_ff;
      end
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = {1'b0, s2_ram_en_ff, s2_mirror_ff, s2_rdata_ff, s2_map_ff, s2_target_ff};

   // no requests while the ram sweep runs
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !req_tready)
      else $error("request accepted during ram clear");

   // marker never drops below bit 3
   a_shift_marker: assert property (@(posedge clock) disable iff (reset)
      shift_ff[2:0] == 3'd0)
      else $error("serial register marker out of range");

   // read data only on prg ram responses
   a_rdata_target: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (s2_rdata_ff != '0)) |-> (s2_target_ff == sbsm_pkg::TARGET_PRG_RAM))
      else $error("read data on a non ram response");

   // staged word is kept while the output stalls
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_valid_ff && !rsp_tready) |=> (s1_valid_ff && s2_valid_ff))
      else $error("word lost under stall");

endmodule
